// ===== src/b64e_pkg.sv =====
`default_nettype none

package b64e_pkg;

  // Number of alphabet characters that a job carries before its pad characters
  localparam logic [2:0] NS_NONE = 3'd0;  // no group, terminator only
  localparam logic [2:0] NS_PAD2 = 3'd2;  // one byte held: two chars, two pads
  localparam logic [2:0] NS_PAD1 = 3'd3;  // two bytes held: three chars, one pad
  localparam logic [2:0] NS_FULL = 3'd4;  // full group of three bytes

  localparam logic [6:0] PAD_CHAR  = 7'h3D;  // '='
  localparam logic [6:0] TERM_CHAR = 7'h00;

  // Character position within a job; position four is the terminator
  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_FOURTH = 3'd3;
  localparam logic [2:0] POS_TERM = 3'd4;

  typedef struct packed {
    logic [23:0] group;  // first byte in the top bits
    logic [2:0]  nsext;  // one of the NS_* codes
    logic        term;   // close the message with a terminator
  } job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    c = {1'b0, v};
    case (v) inside
      [6'd0 : 6'd25]:  c = 7'h41 + {1'b0, v};
      [6'd26 : 6'd51]: c = 7'h61 + ({1'b0, v} - 7'd26);
      [6'd52 : 6'd61]: c = 7'h30 + ({1'b0, v} - 7'd52);
      6'd62:           c = 7'h2B;
      default:         c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/base64_stream_encoder.sv =====
`default_nettype none

// Channel  Dir  tdata                 tuser        tlast
// s_*      in   [7:0] data_byte       has_byte     end_of_message
// m_*      out  [6:0] out_char, [7]=0 (none)       is_last
//
// A beat is taken in every cycle while the job queue has room. The back end
// emits one character per cycle while a job waits and the output is not
// stalled, so a completed group yields four characters and a flush up to
// five; the character serializer sets the sustained rate.
// Reset (rst, synchronous) clears held bytes, queue and output register.
// A stall on m_tready holds the output beat and, once the queue fills,
// drops s_tready; the front keeps taking beats that add no characters only
// while the queue has room.

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tuser,   // [0] has_byte
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [6:0] out_char, [7] zero
  output logic            m_tlast
);

  job_t new_job;
  job_t head_job;
  logic push;
  logic pop;
  logic head_valid;
  logic full;
  logic accept;

  // Hold the input whenever a job might not fit in the queue
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  // Front: gather bytes into groups and classify the flush
  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (s_tdata),
    .has_byte       (s_tuser),
    .end_of_message (s_tlast),
    .job            (new_job),
    .push           (push)
  );

  // Short job queue decouples the byte side from the character side
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (new_job),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .full       (full)
  );

  // Back: serialize characters, pads and terminator into the output register
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_valid (head_valid),
    .job_pop   (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== src/b64e_front.sv =====
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       has_byte,
  input  wire logic       end_of_message,
  output job_t            job,
  output logic            push
);

  logic [15:0] held;
  logic [1:0]  held_cnt;
  logic [15:0] held_next;
  logic [1:0]  held_cnt_next;

  always_comb begin
    logic [15:0] h;
    logic [1:0]  c;
    logic        full_done;
    h = held;
    c = held_cnt;
    full_done = 1'b0;
    job.group = 24'd0;
    job.nsext = NS_NONE;
    job.term  = 1'b0;

    if (has_byte) begin
      if (c == 2'd2) begin
        job.group = {h, data_byte};
        job.nsext = NS_FULL;
        full_done = 1'b1;
        h = 16'd0;
        c = 2'd0;
      end else if (c == 2'd1) begin
        h = {h[15:8], data_byte};
        c = 2'd2;
      end else begin
        h = {data_byte, 8'd0};
        c = 2'd1;
      end
    end

    if (end_of_message) begin
      job.term = 1'b1;
      if (!full_done) begin
        job.group = {h, 8'd0};
        case (c)
          2'd1:    job.nsext = NS_PAD2;
          2'd2:    job.nsext = NS_PAD1;
          default: job.nsext = NS_NONE;
        endcase
      end
      h = 16'd0;
      c = 2'd0;
    end

    held_next     = h;
    held_cnt_next = c;
    push          = accept && (full_done || end_of_message);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= 16'd0;
      held_cnt <= 2'd0;
    end else if (accept) begin
      held     <= held_next;
      held_cnt <= held_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/b64e_queue.sv =====
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      head_valid,
  output logic      full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_job   = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/b64e_back.sv =====
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  job_t            job,
  input  wire logic       job_valid,
  output logic            job_pop,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);

  logic [2:0] pos;
  logic [2:0] eff_pos;
  logic [6:0] char_next;
  logic       last_next;
  logic       job_done;
  logic       advance;
  logic [5:0] sext;

  // A terminator-only job starts straight at the terminator slot
  assign eff_pos = (pos == POS_FIRST && job.nsext == NS_NONE) ? POS_TERM : pos;

  always_comb begin
    case (eff_pos[1:0])
      2'd0:    sext = job.group[23:18];
      2'd1:    sext = job.group[17:12];
      2'd2:    sext = job.group[11:6];
      default: sext = job.group[5:0];
    endcase

    if (eff_pos == POS_TERM) begin
      char_next = TERM_CHAR;
      last_next = 1'b1;
    end else if (eff_pos < job.nsext) begin
      char_next = sextet_char(sext);
      last_next = 1'b0;
    end else begin
      char_next = PAD_CHAR;
      last_next = 1'b0;
    end
  end

  assign job_done = (eff_pos == POS_TERM) || (eff_pos == POS_FOURTH && !job.term);
  assign advance  = job_valid && (!m_tvalid || m_tready);
  assign job_pop  = advance && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_FIRST;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      pos      <= job_done ? POS_FIRST : eff_pos + 3'd1;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, char_next};
      m_tlast <= last_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/b64e_checker.sv =====
`default_nettype none

module b64e_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // Stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed under stall");

  // Output register empties on reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Terminator is a zero character
  a_term: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == 8'd0)
    else $error("last beat is not the terminator");

  // Every other character is a nonzero 7-bit code
  a_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata != 8'd0 && !m_tdata[7])
    else $error("bad character code");

endmodule

bind base64_stream_encoder b64e_checker u_chk (.*);

`default_nettype wire

// ===== verif/base64_stream_encoder_tb.sv =====
module base64_stream_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  // One predicted output beat
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } b64_beat_t;

  // Predict the character stream from accepted input beats, then match each
  // output beat against the oldest character still owed.
  class b64_char_scoreboard;
    string     alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    b64_beat_t pending_chars[$];
    bit [15:0] held_bytes;
    bit [1:0]  held_count;
    int        errors;

    function logic [6:0] sextet_to_char(bit [5:0] v);
      byte b;
      b = alphabet.getc(v);
      return b[6:0];
    endfunction

    function void owe_char(logic [6:0] ch, logic last);
      b64_beat_t b;
      b.ch = ch;
      b.last = last;
      pending_chars.push_back(b);
    endfunction

    function void note_beat(bit [7:0] data_byte, bit has_byte, bit end_of_message);
      bit [23:0] grp;
      if (has_byte) begin
        if (held_count == 2'd2) begin
          grp = {held_bytes, data_byte};
          owe_char(sextet_to_char(grp[23:18]), 1'b0);
          owe_char(sextet_to_char(grp[17:12]), 1'b0);
          owe_char(sextet_to_char(grp[11:6]), 1'b0);
          owe_char(sextet_to_char(grp[5:0]), 1'b0);
          held_bytes = '0;
          held_count = 2'd0;
        end else if (held_count == 2'd1) begin
          held_bytes[7:0] = data_byte;
          held_count = 2'd2;
        end else begin
          held_bytes = {data_byte, 8'h00};
          held_count = 2'd1;
        end
      end
      if (end_of_message) begin
        // Flush the partial group with padding, then close with the terminator
        grp = {held_bytes, 8'h00};
        if (held_count == 2'd1) begin
          owe_char(sextet_to_char(grp[23:18]), 1'b0);
          owe_char(sextet_to_char(grp[17:12]), 1'b0);
          owe_char(PAD_CHAR, 1'b0);
          owe_char(PAD_CHAR, 1'b0);
        end else if (held_count == 2'd2) begin
          owe_char(sextet_to_char(grp[23:18]), 1'b0);
          owe_char(sextet_to_char(grp[17:12]), 1'b0);
          owe_char(sextet_to_char(grp[11:6]), 1'b0);
          owe_char(PAD_CHAR, 1'b0);
        end
        owe_char(TERM_CHAR, 1'b1);
        held_bytes = '0;
        held_count = 2'd0;
      end
    endfunction

    function void check_char(logic [7:0] tdata, logic tlast);
      b64_beat_t want;
      if (pending_chars.size() == 0) begin
        $error("out_char: no character expected, got %h (is_last %b)", tdata, tlast);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      // Bit 7 of tdata is fill and must read zero
      if (tdata !== {1'b0, want.ch}) begin
        $error("out_char mismatch: expected %h, got %h", {1'b0, want.ch}, tdata);
        errors++;
      end
      if (tlast !== want.last) begin
        $error("is_last mismatch: expected %b, got %b", want.last, tlast);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;  // [7:0] data_byte
  logic       s_tuser = 1'b0;   // [0] has_byte
  logic       s_tlast = 1'b0;   // end_of_message
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [6:0] out_char, [7] zero
  logic       m_tlast;          // is_last

  b64_char_scoreboard chars_sb = new();

  // Sender burst shaping
  int burst_left = 0;
  // Receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  // Accepted input beats
  int msg_beats = 0;

  base64_stream_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Receiver: switch at random between always-ready, coin-flip, long stalls
  // and light stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_left <= $urandom_range(80, 20);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(1));
      2:       m_tready <= ($urandom_range(7) == 0);
      default: m_tready <= ($urandom_range(3) != 0);
    endcase
  end

  // Check every output beat against the prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) chars_sb.check_char(m_tdata, m_tlast);
  end

  // Present one beat and hold it until accepted. Keep tvalid high while the
  // burst lasts; otherwise drop it for a random gap.
  task automatic send_beat(input bit [7:0] data_byte, input bit has_byte,
                           input bit end_of_message);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= data_byte;
    s_tuser  <= has_byte;
    s_tlast  <= end_of_message;
    do @(posedge clk); while (!s_tready);
    chars_sb.note_beat(data_byte, has_byte, end_of_message);
    msg_beats++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12);
      gap = $urandom_range(6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every owed character has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (chars_sb.pending_chars.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // One message of random bytes; end it on the last byte or with a bare
  // marker, with an occasional idle beat mixed in.
  task automatic send_message(input int n_bytes);
    bit end_on_byte;
    end_on_byte = (n_bytes > 0) && $urandom_range(1);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(11) == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1, end_on_byte && (i == n_bytes - 1));
    end
    if (!end_on_byte) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty message: terminator alone
    send_beat(8'h00, 1'b0, 1'b1);
    // Idle beat: no effect
    send_beat(8'hA5, 1'b0, 1'b0);
    // Single byte with end on the same beat: two chars, two pads
    send_beat(8'h00, 1'b1, 1'b1);
    // Two bytes, bare end whose data is ignored: three chars, one pad
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);
    // All-zero group, then a group completed on the end beat
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h4D, 1'b1, 1'b0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h6E, 1'b1, 1'b1);
    // Idle beat in the middle of a message
    send_beat(8'h3E, 1'b1, 1'b0);
    send_beat(8'hC3, 1'b0, 1'b0);
    send_beat(8'hF0, 1'b1, 1'b1);
    // Sextets 62 and 63, then a lone byte with end after a full group
    send_beat(8'hFB, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hBF, 1'b1, 1'b0);
    send_beat(8'hE0, 1'b1, 1'b1);

    wait_drained();

    for (int m = 0; msg_beats < 170; m++) begin
      if ($urandom_range(7) == 0) send_message($urandom_range(20));
      else send_message($urandom_range(7));
      if (m == 12) wait_drained();
    end

    wait_drained();
    if (chars_sb.errors == 0 && chars_sb.pending_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
src/b64e_checker.sv
verif/base64_stream_encoder_tb.sv
